>>> src/assert_macros.svh
// Concurrent assertion macros shared by the stripper modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> src/htsu_pkg.sv
// Types, character codes and entity tables for the HTML text stripper
`timescale 1ns / 1ps

package htsu_pkg;

  localparam int COUNT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int CAP_BITS        = 17;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 17'd4096;
  localparam int NUM_ENT         = 5;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_R     = 8'h72;

  localparam logic [7:0] ENT_PAT [NUM_ENT][8] = '{
    '{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B, 8'h00, 8'h00, 8'h00},
    '{8'h23, 8'h33, 8'h39, 8'h3B, 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] ENT_LEN  [NUM_ENT] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd4};
  localparam logic [7:0] ENT_CHAR [NUM_ENT] = '{8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27};

  typedef enum logic [3:0] {
    MODE_TEXT = 4'b0001,
    MODE_TAG  = 4'b0010,
    MODE_ENT  = 4'b0100,
    MODE_SKIP = 4'b1000
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        char_valid;
    logic [7:0]  out_char;
    logic [15:0] char_count;
    logic        message_done;
  } out_item_t;

  typedef struct packed {
    logic       emit_req;
    logic [7:0] ch;
    logic       last;
  } emit_item_t;

endpackage

>>> src/htsu_front.sv
// Byte classifier: tag, entity and whitespace scanning, emits character requests
`timescale 1ns / 1ps
`include "assert_macros.svh"

module htsu_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  htsu_pkg::in_item_t   in_data,
  output logic                 push_valid,
  input  logic                 push_ready,
  output htsu_pkg::emit_item_t push_data
);
  import htsu_pkg::*;

  scan_mode_t       scan_mode, scan_mode_next;
  logic [1:0]       tag_position, tag_position_next;
  logic [1:0]       tag_match_flags, tag_match_flags_next;
  logic [2:0]       entity_position, entity_position_next;
  logic [NUM_ENT-1:0] entity_candidates, entity_candidates_next;
  logic             after_space, after_space_next;
  logic             in_fire;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign in_fire    = in_valid && push_ready;

  always_comb begin
    logic [7:0]         b;
    logic [1:0]         keep;
    logic [NUM_ENT-1:0] alive;
    logic               done;
    logic [7:0]         done_ch;
    b = in_data.in_byte;
    keep = 2'b00;
    alive = '0;
    done = 1'b0;
    done_ch = 8'h00;
    scan_mode_next = scan_mode;
    tag_position_next = tag_position;
    tag_match_flags_next = tag_match_flags;
    entity_position_next = entity_position;
    entity_candidates_next = entity_candidates;
    after_space_next = after_space;
    push_data.emit_req = 1'b0;
    push_data.ch = 8'h00;
    push_data.last = in_data.last_byte;
    unique case (scan_mode)
      MODE_TEXT: begin
        if (b == CH_LT) begin
          scan_mode_next = MODE_TAG;
          tag_position_next = 2'd1;
          tag_match_flags_next = 2'b11;
        end else if (b == CH_AMP) begin
          scan_mode_next = MODE_ENT;
          entity_position_next = 3'd0;
          entity_candidates_next = '1;
        end else if (b == CH_CR) begin
          push_data.emit_req = 1'b0;
        end else if (b == CH_SPACE || b == CH_TAB || b == CH_LF) begin
          if (!after_space) begin
            push_data.emit_req = 1'b1;
            push_data.ch = (b == CH_LF) ? CH_LF : CH_SPACE;
            after_space_next = 1'b1;
          end
        end else begin
          push_data.emit_req = 1'b1;
          push_data.ch = b;
          after_space_next = 1'b0;
        end
      end
      MODE_TAG: begin
        if (tag_position == 2'd1) begin
          keep = {b == CH_SLASH, b == CH_B};
          tag_match_flags_next = tag_match_flags & keep;
          tag_position_next = 2'd2;
        end else if (tag_position == 2'd2) begin
          if ((tag_match_flags[0] && b == CH_R) || (tag_match_flags[1] && b == CH_P)) begin
            push_data.emit_req = 1'b1;
            push_data.ch = CH_LF;
            after_space_next = 1'b1;
          end
          tag_position_next = 2'd3;
        end
        if (b == CH_GT) begin
          scan_mode_next = MODE_TEXT;
        end
      end
      MODE_ENT: begin
        for (int c = 0; c < NUM_ENT; c++) begin
          if (entity_candidates[c] && entity_position < ENT_LEN[c] &&
              ENT_PAT[c][entity_position] == b) begin
            alive[c] = 1'b1;
            if (entity_position + 3'd1 == ENT_LEN[c]) begin
              done = 1'b1;
              done_ch = ENT_CHAR[c];
            end
          end
        end
        entity_candidates_next = alive;
        if (entity_position != 3'd7) begin
          entity_position_next = entity_position + 3'd1;
        end
        if (done) begin
          scan_mode_next = MODE_TEXT;
          after_space_next = 1'b0;
          push_data.emit_req = 1'b1;
          push_data.ch = done_ch;
        end else if (alive == '0) begin
          scan_mode_next = (b == CH_SEMI) ? MODE_TEXT : MODE_SKIP;
        end
      end
      MODE_SKIP: begin
        if (b == CH_SEMI) begin
          scan_mode_next = MODE_TEXT;
        end
      end
      default: begin
        scan_mode_next = MODE_TEXT;
      end
    endcase
    // drop all message state after the final byte
    if (in_data.last_byte) begin
      scan_mode_next = MODE_TEXT;
      tag_position_next = 2'd0;
      tag_match_flags_next = 2'b11;
      entity_position_next = 3'd0;
      entity_candidates_next = '1;
      after_space_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode <= MODE_TEXT;
      tag_position <= 2'd0;
      tag_match_flags <= 2'b11;
      entity_position <= 3'd0;
      entity_candidates <= '1;
      after_space <= 1'b1;
    end else if (in_fire) begin
      scan_mode <= scan_mode_next;
      tag_position <= tag_position_next;
      tag_match_flags <= tag_match_flags_next;
      entity_position <= entity_position_next;
      entity_candidates <= entity_candidates_next;
      after_space <= after_space_next;
    end
  end

  `ASSERT_CLK(a_tag_emit_third, clk, rst,
    (in_fire && scan_mode == MODE_TAG && push_data.emit_req) |-> (tag_position == 2'd2),
    "tag newline outside third tag byte")
  `ASSERT_CLK(a_last_clears, clk, rst,
    (in_fire && in_data.last_byte) |=> (scan_mode == MODE_TEXT && after_space),
    "state not cleared after final byte")

endmodule

>>> src/htsu_queue.sv
// Small FIFO between the classifier and the emit stage
`timescale 1ns / 1ps
`include "assert_macros.svh"

module htsu_queue #(
  parameter int DEPTH = htsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  htsu_pkg::emit_item_t wr_data,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output htsu_pkg::emit_item_t rd_data
);
  import htsu_pkg::*;

  localparam int PTR_BITS = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  emit_item_t          store [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0] fill;
  logic                push, pop;

  assign wr_ready = (fill != FULL_CNT);
  assign rd_valid = (fill != '0);
  assign rd_data  = store[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_fill_range, clk, rst, fill > FULL_CNT, "queue fill beyond depth")
  `ASSERT_CLK(a_push_lands, clk, rst, (push && !pop) |=> rd_valid,
    "queue empty after a push")

endmodule

>>> src/htsu_back.sv
// Emit stage: capacity check, character count and registered output
`timescale 1ns / 1ps
`include "assert_macros.svh"

module htsu_back #(
  parameter int COUNT_BITS = htsu_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [htsu_pkg::CAP_BITS-1:0]   cfg_data,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  htsu_pkg::emit_item_t            q_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output htsu_pkg::out_item_t             out_data
);
  import htsu_pkg::*;

  localparam int CW = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 1;

  logic [CAP_BITS-1:0]   out_capacity;
  logic [COUNT_BITS-1:0] emitted_count, emitted_count_next;
  logic [CW-1:0]         count_plus, count_wide;
  logic                  emit_ok, pop;

  assign cfg_ready  = 1'b1;
  assign q_ready    = !out_valid || out_ready;
  assign pop        = q_valid && q_ready;
  assign count_plus = CW'(emitted_count) + CW'(1);
  assign emit_ok    = q_data.emit_req && (count_plus < CW'(out_capacity)) &&
                      (emitted_count != '1);
  assign emitted_count_next = emit_ok ? emitted_count + 1'b1 : emitted_count;
  assign count_wide = CW'(emitted_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      out_capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emitted_count <= '0;
      out_valid <= 1'b0;
    end else if (pop) begin
      emitted_count <= q_data.last ? '0 : emitted_count_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.char_valid <= emit_ok;
      out_data.out_char <= emit_ok ? q_data.ch : 8'h00;
      out_data.char_count <= count_wide[15:0];
      out_data.message_done <= q_data.last;
    end
  end

  `ASSERT_CLK(a_no_req_no_char, clk, rst,
    (pop && !q_data.emit_req) |=> (!out_data.char_valid && out_data.out_char == 8'h00),
    "character shown without a request")

endmodule

>>> src/html_text_stripper_unit.sv
// Top level of the HTML text stripper: classifier, queue and emit stage
//
//   channel  signals                        width        direction
//   in       in_valid / in_ready / in_data  in_item_t    HTML bytes in
//   out      out_valid / out_ready / out_data out_item_t one result per byte out
//   cfg      cfg_valid / cfg_ready / cfg_data 17 bits    output capacity write
//
// One byte per cycle unless output stalls; results are queued, then registered for output.
// The classifier updates scan state in the accept cycle; the emit stage
// counts and registers the result. Reset clears all state, capacity to 4096.
// An output stall fills the queue (QUEUE_DEPTH entries) plus the output register
// before in_ready drops.
`timescale 1ns / 1ps

module html_text_stripper_unit #(
  parameter int COUNT_BITS  = htsu_pkg::COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = htsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  htsu_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output htsu_pkg::out_item_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [htsu_pkg::CAP_BITS-1:0] cfg_data
);
  import htsu_pkg::*;

  emit_item_t push_data, q_data;
  logic       push_valid, push_ready, q_valid, q_ready;

  htsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  htsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  htsu_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> dv/tb_html_text_stripper_unit.sv
// Self-checking testbench for html_text_stripper_unit: random markup, capacities, backpressure
`timescale 1ns / 1ps
module tb_html_text_stripper_unit;
  import htsu_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 80;
  localparam int MAX_REPORTS    = 40;
  localparam logic [7:0] SPECIALS [12] = '{CH_LT, CH_GT, CH_AMP, CH_SEMI, CH_CR, CH_LF,
                                           CH_SPACE, CH_TAB, CH_B, CH_R, CH_SLASH, CH_P};
  localparam logic [7:0] WS_CHARS [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_BITS-1:0] cfg_data  = '0;

  html_text_stripper_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  scan_mode_t          strip_mode;
  logic [1:0]          tag_pos;
  logic [1:0]          tag_flags;
  logic [2:0]          ent_pos;
  logic [NUM_ENT-1:0]  ent_alive;
  logic                in_space;
  logic [15:0]         char_total;
  logic [CAP_BITS-1:0] cap_reg;

  out_item_t  expected_chars [$];
  logic [7:0] msg_bytes [$];
  int         err_count   = 0;
  int         items_sent  = 0;
  int         tx_mode     = 0;
  int         rx_mode     = 0;
  bit         rx_hold_req = 1'b0;
  int         hold_left   = 0;
  int         rx_wait     = 0;
  int         idle_cycles = 0;

  string tag_bodies [12] = '{"br", "/p", "br/", "b", "/", "p", "/pre", "bq", "div", "/br",
                             "BR", "brx"};
  string ent_bodies [15] = '{"amp;", "lt;", "gt;", "quot;", "#39;", "am;", "ampx;", "quo;",
                             "#3;", "x;", ";", "lt", "gtt;", "#39", "qu;"};

  function automatic void clear_strip_state();
    strip_mode = MODE_TEXT;
    tag_pos    = 2'd0;
    tag_flags  = 2'b11;
    ent_pos    = 3'd0;
    ent_alive  = '1;
    in_space   = 1'b1;
    char_total = 16'd0;
  endfunction

  function automatic void try_emit(inout out_item_t r, input logic [7:0] c);
    if ({1'b0, char_total} + 17'd1 < cap_reg && char_total != 16'hFFFF) begin
      char_total++;
      r.char_valid = 1'b1;
      r.out_char   = c;
    end
  endfunction

  function automatic out_item_t strip_byte(in_item_t it);
    out_item_t          r;
    logic [7:0]         b;
    logic [1:0]         keep;
    logic [NUM_ENT-1:0] alive;
    int                 hit;
    r     = '0;
    b     = it.in_byte;
    keep  = 2'b00;
    alive = '0;
    hit   = -1;
    case (strip_mode)
      MODE_TEXT: begin
        if (b == CH_LT) begin
          strip_mode = MODE_TAG;
          tag_pos    = 2'd1;
          tag_flags  = 2'b11;
        end else if (b == CH_AMP) begin
          strip_mode = MODE_ENT;
          ent_pos    = 3'd0;
          ent_alive  = '1;
        end else if (b == CH_CR) begin
        end else if (b == CH_SPACE || b == CH_TAB || b == CH_LF) begin
          if (!in_space) begin
            try_emit(r, (b == CH_LF) ? CH_LF : CH_SPACE);
            in_space = 1'b1;
          end
        end else begin
          in_space = 1'b0;
          try_emit(r, b);
        end
      end
      MODE_TAG: begin
        if (tag_pos == 2'd1) begin
          if (b == CH_B) keep[0] = 1'b1;
          if (b == CH_SLASH) keep[1] = 1'b1;
          tag_flags = tag_flags & keep;
          tag_pos   = 2'd2;
        end else if (tag_pos == 2'd2) begin
          if ((tag_flags[0] && b == CH_R) || (tag_flags[1] && b == CH_P)) begin
            try_emit(r, CH_LF);
            in_space = 1'b1;
          end
          tag_pos = 2'd3;
        end
        if (b == CH_GT) strip_mode = MODE_TEXT;
      end
      MODE_ENT: begin
        for (int c = 0; c < NUM_ENT; c++) begin
          if (ent_alive[c] && ent_pos < ENT_LEN[c] && ENT_PAT[c][ent_pos] == b) begin
            alive[c] = 1'b1;
            if ({1'b0, ent_pos} + 4'd1 == {1'b0, ENT_LEN[c]}) hit = c;
          end
        end
        ent_alive = alive;
        if (ent_pos < 3'd7) ent_pos++;
        if (hit >= 0) begin
          strip_mode = MODE_TEXT;
          in_space   = 1'b0;
          try_emit(r, ENT_CHAR[hit]);
        end else if (alive == '0) begin
          strip_mode = (b == CH_SEMI) ? MODE_TEXT : MODE_SKIP;
        end
      end
      default: begin
        if (b == CH_SEMI) strip_mode = MODE_TEXT;
      end
    endcase
    r.char_count   = char_total;
    r.message_done = it.last_byte;
    if (it.last_byte) clear_strip_state();
    return r;
  endfunction

  function automatic int draw_gap(int gap_mode);
    if (gap_mode == 1) return $urandom_range(0, 14);
    if (gap_mode == 2) return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
    return 0;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("mismatch in %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    in_item_t it;
    int       gap;
    it  = '{in_byte: b, last_byte: last};
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    expected_chars.push_back(strip_byte(it));
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic append_text(string s);
    for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
  endtask

  task automatic build_message();
    int         tokens;
    int         kind;
    int         n;
    logic [7:0] c;
    msg_bytes.delete();
    tokens = $urandom_range(1, 10);
    repeat (tokens) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          c = 8'($urandom_range(33, 126));
          if (c == CH_LT || c == CH_AMP) c = 8'h78;
          if ($urandom_range(0, 7) == 0) c = 8'($urandom_range(128, 255));
          msg_bytes.push_back(c);
        end
      end else if (kind < 45) begin
        n = $urandom_range(1, 4);
        repeat (n) msg_bytes.push_back(WS_CHARS[$urandom_range(0, 3)]);
      end else if (kind < 60) begin
        msg_bytes.push_back(CH_LT);
        append_text(tag_bodies[$urandom_range(0, 11)]);
        if ($urandom_range(0, 2) == 0) begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_GT) c = CH_SPACE;
            msg_bytes.push_back(c);
          end
        end
        msg_bytes.push_back(CH_GT);
      end else if (kind < 80) begin
        msg_bytes.push_back(CH_AMP);
        append_text(ent_bodies[$urandom_range(0, 14)]);
      end else if (kind < 90) begin
        msg_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        msg_bytes.push_back(SPECIALS[$urandom_range(0, 11)]);
      end
    end
    if (msg_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, msg_bytes.size() - 1);
      while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
    end
  endtask

  task automatic send_random_messages(int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      build_message();
      foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_reg = value;
  endtask

  task automatic run_phase(logic [CAP_BITS-1:0] cap, int tx, int rx, int n);
    drain_results();
    write_capacity(cap);
    tx_mode = tx;
    rx_mode = rx;
    send_random_messages(n);
  endtask

  task automatic test_directed_markup();
    tx_mode = 1;
    rx_mode = 1;
    send_text({"  <br>&amp;&#39;&x;", "\015\n b</p"});
  endtask

  task automatic test_capacity_extremes();
    run_phase(17'd0, 1, 1, 40);
    run_phase(17'd1, 2, 1, 40);
    run_phase(17'd2, 1, 2, 40);
    run_phase(17'd5, 0, 0, 40);
  endtask

  task automatic test_random_markup();
    run_phase(CAP_RESET, 1, 1, 100);
    run_phase(CAP_BITS'($urandom_range(3, 40)), 2, 0, 100);
    run_phase(CAP_BITS'($urandom_range(0, 65536)), 0, 2, 100);
    run_phase(17'd65536, 1, 0, 100);
    run_phase(CAP_BITS'($urandom_range(100, 5000)), 2, 2, 100);
  endtask

  task automatic test_backpressure();
    drain_results();
    tx_mode     = 0;
    rx_mode     = 0;
    rx_hold_req = 1'b1;
    send_random_messages(30);
    drain_results();
    tx_mode = 2;
    rx_mode = 1;
    send_random_messages(30);
  endtask

  task automatic test_long_message();
    drain_results();
    write_capacity(17'd65536);
    tx_mode = 0;
    rx_mode = 0;
    for (int i = 0; i < 40; i++) send_byte(8'h61, i == 39);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_hold_req) begin
        hold_left   = LONG_HOLD;
        rx_hold_req = 1'b0;
      end
      if (out_valid && out_ready) rx_wait = draw_gap(rx_mode);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected transaction, out_char", out_data.out_char, -1);
      end else begin
        want = expected_chars.pop_front();
        if (out_data.char_valid !== want.char_valid)
          report_mismatch("char_valid", out_data.char_valid, want.char_valid);
        if (out_data.out_char !== want.out_char)
          report_mismatch("out_char", out_data.out_char, want.out_char);
        if (out_data.char_count !== want.char_count)
          report_mismatch("char_count", out_data.char_count, want.char_count);
        if (out_data.message_done !== want.message_done)
          report_mismatch("message_done", out_data.message_done, want.message_done);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    clear_strip_state();
    cap_reg = CAP_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed_markup();
    test_capacity_extremes();
    test_random_markup();
    test_backpressure();
    test_long_message();
    drain_results();
    repeat (10) @(posedge clk);
    if (expected_chars.size() != 0)
      report_mismatch("missing results", 0, expected_chars.size());
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/htsu_pkg.sv
src/htsu_front.sv
src/htsu_queue.sv
src/htsu_back.sv
src/html_text_stripper_unit.sv
dv/tb_html_text_stripper_unit.sv
